// ----- src/fkoc_pkg.sv -----
`timescale 1ns / 1ps

package fkoc_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int CPLX_W      = 16;
  localparam int NUM_KEYS    = 9;
  localparam int WIN_DEPTH   = 21;
  localparam int KEY_MAX_LEN = WIN_DEPTH + 1;
  localparam int KEY_BITS    = BYTE_W * KEY_MAX_LEN;
  localparam int HOLD_W      = 5;
  localparam int HIT_W       = $clog2(NUM_KEYS + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Saturated total seen on the 16-bit result field
  localparam logic [CPLX_W+COUNT_WIDTH-1:0] SAT_EXT  = {{CPLX_W{1'b0}}, COUNT_MAX};
  localparam logic [CPLX_W-1:0]             SAT_CPLX = SAT_EXT[CPLX_W-1:0];

  // Keywords right-aligned: byte d (from the bottom) is the char d places before the end
  localparam logic [KEY_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
    {"if", "_statement"},
    {"elif", "_statement"},
    {"for", "_statement"},
    {"while", "_statement"},
    {"try", "_statement"},
    {"finally", "_clause"},
    {"case", "_clause"},
    "assert",
    {"conditional", "_expression"}
  };

  localparam logic [HOLD_W-1:0] KEY_LEN [NUM_KEYS] = '{
    5'd12, 5'd14, 5'd13, 5'd15, 5'd13, 5'd14, 5'd11, 5'd6, 5'd22
  };

  typedef struct packed {
    logic step;   // process the held byte this cycle
    logic clear;  // byte is the last of its text: return to reset state afterwards
  } fkoc_ctrl_t;

endpackage

// ----- src/fkoc_match.sv -----
`timescale 1ns / 1ps

module fkoc_match (
  input  logic                      clk,
  input  logic                      rst,
  input  fkoc_pkg::fkoc_ctrl_t      ctrl,
  input  logic [fkoc_pkg::BYTE_W-1:0] text_byte,
  output logic [fkoc_pkg::HIT_W-1:0]  hits
);
  import fkoc_pkg::*;

  logic [BYTE_W-1:0] window [WIN_DEPTH];
  logic [HOLD_W-1:0] holdoff [NUM_KEYS];
  logic [BYTE_W-1:0] taps [KEY_MAX_LEN];
  logic [NUM_KEYS-1:0] hit_vec;

  always_comb begin
    taps[0] = text_byte;
    for (int d = 1; d < KEY_MAX_LEN; d++) begin
      taps[d] = window[d-1];
    end
  end

  // One comparator row per keyword; bytes beyond the keyword length don't care
  always_comb begin
    logic eq;
    hit_vec = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      eq = 1'b1;
      for (int d = 0; d < KEY_MAX_LEN; d++) begin
        if (HOLD_W'(d) < KEY_LEN[k] && taps[d] != KEY_TEXT[k][BYTE_W*d +: BYTE_W]) begin
          eq = 1'b0;
        end
      end
      hit_vec[k] = eq && (holdoff[k] == '0);
    end
  end

  always_comb begin
    hits = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hits = hits + HIT_W'(hit_vec[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) window[i] <= '0;
      for (int k = 0; k < NUM_KEYS; k++) holdoff[k] <= '0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        for (int i = 0; i < WIN_DEPTH; i++) window[i] <= '0;
        for (int k = 0; k < NUM_KEYS; k++) holdoff[k] <= '0;
      end else begin
        window[0] <= text_byte;
        for (int i = 1; i < WIN_DEPTH; i++) window[i] <= window[i-1];
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (holdoff[k] != '0) begin
            holdoff[k] <= holdoff[k] - 1'b1;
          end else if (hit_vec[k]) begin
            holdoff[k] <= KEY_LEN[k] - 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- src/fkoc_accum.sv -----
`timescale 1ns / 1ps

module fkoc_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  fkoc_pkg::fkoc_ctrl_t        ctrl,
  input  logic [fkoc_pkg::HIT_W-1:0]  hits,
  output logic [fkoc_pkg::CPLX_W-1:0] complexity,
  output logic                        saturated
);
  import fkoc_pkg::*;

  logic [COUNT_WIDTH-1:0]        total;
  logic [COUNT_WIDTH-1:0]        total_next;
  logic [COUNT_WIDTH:0]          sum;
  logic [COUNT_WIDTH-1:0]        cplx_full;
  logic [CPLX_W+COUNT_WIDTH-1:0] cplx_ext;

  always_comb begin
    sum        = {1'b0, total} + (COUNT_WIDTH+1)'(hits);
    total_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
    saturated  = (total_next == COUNT_MAX);
    cplx_full  = saturated ? COUNT_MAX : total_next + 1'b1;
    cplx_ext   = {{CPLX_W{1'b0}}, cplx_full};
    complexity = cplx_ext[CPLX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctrl.step) begin
      total <= ctrl.clear ? '0 : total_next;
    end
  end

endmodule

// ----- src/fixed_keyword_occurrence_counter_unit.sv -----
`timescale 1ns / 1ps
// m_tvalid rises after the final byte of a text is accepted and has passed through
// the input register, then match/count logic into the result register.
// Throughput: one byte per cycle; s_tready drops only when a final byte waits
// for the result register to empty.
// Reset (rst, synchronous): clears the byte window, hold-offs, total and valids.

module fixed_keyword_occurrence_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] complexity
  output logic [0:0]  m_tuser    // [0] saturated
);
  import fkoc_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_final;
  logic              consume;
  fkoc_ctrl_t        ctrl;
  logic [HIT_W-1:0]  hits;
  logic [CPLX_W-1:0] complexity;
  logic              saturated;
  logic [CPLX_W-1:0] out_cplx;
  logic              out_sat;
  logic              out_valid;

  // A non-final byte never needs the result register
  assign consume  = in_valid && (!in_final || !out_valid || m_tready);
  assign s_tready = !in_valid || consume;

  assign ctrl.step  = consume;
  assign ctrl.clear = in_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  fkoc_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .text_byte (in_byte),
    .hits      (hits)
  );

  fkoc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hits       (hits),
    .complexity (complexity),
    .saturated  (saturated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && in_final) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_final) begin
      out_cplx <= complexity;
      out_sat  <= saturated;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_cplx;
  assign m_tuser[0] = out_sat;

endmodule

// ----- src/fkoc_checker.sv -----
`timescale 1ns / 1ps

module fkoc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);
  import fkoc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Complexity is one plus a count, never zero
  a_cplx_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != '0)
    else $error("zero complexity");

  // Saturation flag pins the value at the limit
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == SAT_CPLX)
    else $error("saturated flag with non-limit value");

  // No result directly out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Input may only stall while a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with free result register");

endmodule

bind fixed_keyword_occurrence_counter_unit fkoc_checker u_fkoc_checker (.*);

// ----- tb/fixed_keyword_occurrence_counter_unit_tb.sv -----
`timescale 1ns / 1ps

module fixed_keyword_occurrence_counter_unit_tb;
  import fkoc_pkg::*;

  typedef struct packed {
    logic [CPLX_W-1:0] complexity;
    logic              saturated;
  } tally_t;

  class fkoc_tally_board;
    string                  kw [NUM_KEYS];
    logic [BYTE_W-1:0]      window [WIN_DEPTH];
    logic [HOLD_W-1:0]      holdoff [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] total;
    tally_t                 owed_q [$];
    int                     mismatches;
    int                     checked;
    int                     sat_seen;
    int                     text_cnt;
    int                     byte_cnt;

    function new();
      string st;
      string cl;
      string ex;
      st = "_statement";
      cl = "_clause";
      ex = "_expression";
      kw = '{{"if", st}, {"elif", st}, {"for", st}, {"while", st},
             {"try", st}, {"finally", cl}, {"case", cl}, "assert",
             {"conditional", ex}};
      mismatches = 0;
      checked    = 0;
      sat_seen   = 0;
      text_cnt   = 0;
      byte_cnt   = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      foreach (holdoff[i]) holdoff[i] = '0;
      total = '0;
    endfunction

    // Advance the keyword matchers by one accepted byte; owe a tally on the last byte.
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      int                   len;
      bit                   hit;
      logic [BYTE_W-1:0]    key_c;
      logic [BYTE_W-1:0]    got_c;
      logic [COUNT_WIDTH:0] wide;
      tally_t               t;
      byte_cnt++;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (holdoff[k] != '0) begin
          holdoff[k] = holdoff[k] - 1'b1;
        end else begin
          len = kw[k].len();
          hit = 1'b1;
          for (int d = 0; d < len; d++) begin
            key_c = kw[k][len-1-d];
            got_c = (d == 0) ? b : window[d-1];
            if (key_c != got_c) begin
              hit = 1'b0;
              break;
            end
          end
          if (hit) begin
            if (total != '1) total = total + 1'b1;
            holdoff[k] = HOLD_W'(len - 1);
          end
        end
      end
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (last) begin
        wide = {1'b0, total} + 1'b1;
        if (total == '1) wide = {1'b0, total};
        t.complexity = CPLX_W'(wide);
        t.saturated  = (total == '1);
        owed_q.push_back(t);
        text_cnt++;
        clear_text();
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, what);
    endfunction

    function void check_result(logic [CPLX_W-1:0] cplx, logic sat);
      tally_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected result complexity=%0d saturated=%0b", cplx, sat));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (want.saturated) sat_seen++;
      if (cplx !== want.complexity || sat !== want.saturated)
        flag($sformatf("result %0d: complexity exp %0d got %0d, saturated exp %0b got %0b",
                       checked, want.complexity, cplx, want.saturated, sat));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void report_leftover();
      while (owed_q.size() != 0) begin
        flag($sformatf("missing result, complexity %0d", owed_q[0].complexity));
        void'(owed_q.pop_front());
      end
    endfunction
  endclass

  localparam int SRC_IDLE  [4] = '{0, 88, 0, 29};
  localparam int SINK_STALL[4] = '{0, 0, 88, 29};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  logic [7:0] text_q [$];

  fkoc_tally_board board = new();

  fixed_keyword_occurrence_counter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Sink side: check at the edge, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, last);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Hold the source until every owed tally has come back.
  task automatic wait_drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (board.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Whole keyword sequences with random breaks and noise mixed in.
  task automatic build_text();
    int    kind;
    int    k;
    int    len;
    int    pos;
    int    cut;
    string s;
    if ($urandom_range(99) < 35) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(99);
      k    = $urandom_range(NUM_KEYS - 1);
      s    = board.kw[k];
      len  = s.len();
      if (kind < 45) begin
        push_str(s);
      end else if (kind < 55) begin
        push_str(s.substr(0, len - 2));
      end else if (kind < 65) begin
        pos = text_q.size() + $urandom_range(len - 1);
        push_str(s);
        text_q[pos] = text_q[pos] ^ 8'($urandom_range(1, 255));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(255)));
      end else begin
        cut = $urandom_range(1, len - 1);
        push_str(s.substr(0, cut - 1));
        push_str(board.kw[$urandom_range(NUM_KEYS - 1)]);
      end
    end
  endtask

  initial begin
    int ph_items;
    int ph_texts;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, two keywords on one byte, window cleared between texts.
    text_q.push_back(8'h00);
    send_text();
    text_q.push_back(8'hFF);
    send_text();
    push_str(board.kw[1]);
    send_text();
    push_str("ass");
    send_text();
    push_str("ert");
    send_text();
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      ph_items = 0;
      ph_texts = 0;
      while (ph_items < 110 || ph_texts < 10) begin
        build_text();
        ph_items += text_q.size();
        ph_texts++;
        send_text();
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    board.report_leftover();
    $display("Sent %0d texts, %0d bytes, under four source/sink idle mixes",
             board.text_cnt, board.byte_cnt);
    $display("Checked %0d results (%0d clipped), %0d mismatches",
             board.checked, board.sat_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/fkoc_pkg.sv
src/fkoc_match.sv
src/fkoc_accum.sv
src/fixed_keyword_occurrence_counter_unit.sv
src/fkoc_checker.sv
tb/fixed_keyword_occurrence_counter_unit_tb.sv
